// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with asynchronous reset disable
`define GCQ_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// same-cycle implication
`define GCQ_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	`GCQ_ASSERT(lbl, ck, rn, (ante) |-> (cons), msg)

// next-cycle implication
`define GCQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	`GCQ_ASSERT(lbl, ck, rn, (ante) |=> (cons), msg)

`endif

// ===== hdl/gcq_pkg.sv =====
// types, constants and defaults for the gaze contact qualifier
package gcq_pkg;

	localparam int WINDOW_DEFAULT = 10;
	localparam int QUEUE_DEPTH = 2;

	localparam int ANGLE_W = 9;
	localparam int CONF_W = 10;
	localparam int TOL_W = 8;
	localparam int LIMIT_W = 8;
	localparam int COUNT_W = 8;
	localparam int PHASE_W = 2;

	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_TOL = 3'd0,
		REG_CONF_THR  = 3'd1,
		REG_ENTER_LIM = 3'd2,
		REG_PULSE_LIM = 3'd3
	} reg_idx_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE   = 2'd0,
		PH_ENGAGE = 2'd1,
		PH_ASSERT = 2'd2
	} phase_t;

	typedef struct packed {
		logic [TOL_W-1:0]   angle_tolerance;
		logic [CONF_W-1:0]  confidence_threshold;
		logic [LIMIT_W-1:0] enter_hold_limit;
		logic [LIMIT_W-1:0] pulse_hold_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		angle_tolerance:      8'd7,
		confidence_threshold: 10'd100,
		enter_hold_limit:     8'd10,
		pulse_hold_limit:     8'd5
	};

endpackage

// ===== hdl/gaze_contact_qualifier_core.sv =====
// an accepted sample's word passes through the score queue, then the output register, to m_axis
// throughput: one sample per cycle while the score queue has room; the back end updates window/phase once per word
// the two-entry score queue and the output register let each side stall independently
// reset (arst_n low, asynchronous): window, sum, phase and counters cleared, registers to defaults
// configuration writes are always taken (cfg_ready high); unknown indexes are dropped
module gaze_contact_qualifier_core #(
	parameter int WINDOW = gcq_pkg::WINDOW_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// face_angle[8:0], gaze_angle[17:9], face_confidence[27:18], gaze_confidence[37:28]
	input  logic [gcq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// contact_flag[0], phase_now[2:1]
	output logic [gcq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gcq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gcq_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SCORE_W = $clog2(WINDOW / 3 + 1);
	localparam int TOTAL_W = $clog2(WINDOW * (WINDOW / 3) + 1);

	gcq_pkg::cfg_t      cfg_q;
	logic               push;
	logic [SCORE_W-1:0] push_score;
	logic               pop;
	logic [SCORE_W-1:0] pop_score;
	logic               queue_full;
	logic               queue_not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= gcq_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gcq_pkg::REG_ANGLE_TOL: cfg_q.angle_tolerance      <= cfg_data[7:0];
				gcq_pkg::REG_CONF_THR:  cfg_q.confidence_threshold <= cfg_data;
				gcq_pkg::REG_ENTER_LIM: cfg_q.enter_hold_limit     <= cfg_data[7:0];
				gcq_pkg::REG_PULSE_LIM: cfg_q.pulse_hold_limit     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	gcq_front #(
		.WINDOW  (WINDOW),
		.SCORE_W (SCORE_W)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg           (cfg_q),
		.queue_full    (queue_full),
		.push          (push),
		.score         (push_score)
	);

	gcq_fifo #(
		.W     (SCORE_W),
		.DEPTH (gcq_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_score),
		.pop       (pop),
		.pop_data  (pop_score),
		.full      (queue_full),
		.not_empty (queue_not_empty)
	);

	gcq_back #(
		.WINDOW  (WINDOW),
		.SCORE_W (SCORE_W),
		.TOTAL_W (TOTAL_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.queue_not_empty (queue_not_empty),
		.score           (pop_score),
		.pop             (pop),
		.cfg             (cfg_q),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata)
	);

endmodule

// ===== hdl/gcq_front.sv =====
// front end: takes a face sample and classifies it into a score
module gcq_front #(
	parameter int WINDOW = gcq_pkg::WINDOW_DEFAULT,
	parameter int SCORE_W = 4
) (
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [gcq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  gcq_pkg::cfg_t                   cfg,
	input  logic                            queue_full,
	output logic                            push,
	output logic [SCORE_W-1:0]              score
);

	localparam logic [SCORE_W-1:0] OPPOSITE_SCORE = SCORE_W'(WINDOW / 3);

	logic signed [gcq_pkg::ANGLE_W-1:0] face_angle;
	logic signed [gcq_pkg::ANGLE_W-1:0] gaze_angle;
	logic [gcq_pkg::CONF_W-1:0]         face_confidence;
	logic [gcq_pkg::CONF_W-1:0]         gaze_confidence;
	logic [gcq_pkg::ANGLE_W-1:0]        face_mag;
	logic [gcq_pkg::ANGLE_W-1:0]        gaze_mag;
	logic [gcq_pkg::ANGLE_W:0]          mag_diff;
	logic [gcq_pkg::ANGLE_W:0]          mag_diff_abs;
	logic                               conf_ok;
	logic                               opposite;
	logic                               straight;

	assign face_angle      = s_axis_tdata[8:0];
	assign gaze_angle      = s_axis_tdata[17:9];
	assign face_confidence = s_axis_tdata[27:18];
	assign gaze_confidence = s_axis_tdata[37:28];

	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && !queue_full;

	// magnitude of -256 comes out as 256 unsigned
	assign face_mag = face_angle[8] ? (~face_angle + 9'd1) : face_angle;
	assign gaze_mag = gaze_angle[8] ? (~gaze_angle + 9'd1) : gaze_angle;

	assign mag_diff     = {1'b0, face_mag} - {1'b0, gaze_mag};
	assign mag_diff_abs = mag_diff[9] ? (~mag_diff + 10'd1) : mag_diff;

	assign conf_ok = (face_confidence > cfg.confidence_threshold) &&
		(gaze_confidence > cfg.confidence_threshold);

	assign opposite = (face_angle[8] && !gaze_angle[8] && (gaze_angle != '0)) ||
		(!face_angle[8] && (face_angle != '0) && gaze_angle[8]);

	assign straight = (face_mag < {1'b0, cfg.angle_tolerance}) &&
		(mag_diff_abs < {2'b00, cfg.angle_tolerance});

	always_comb begin
		priority if (!conf_ok) begin
			score = '0;
		end else if (opposite) begin
			score = OPPOSITE_SCORE;
		end else if (straight) begin
			score = SCORE_W'(1);
		end else begin
			score = '0;
		end
	end

endmodule

// ===== hdl/gcq_fifo.sv =====
// short score queue between front and back
module gcq_fifo #(
	parameter int W = 4,
	parameter int DEPTH = gcq_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/gcq_back.sv =====
// back end: window sum, phase machine and output word register
module gcq_back #(
	parameter int WINDOW = gcq_pkg::WINDOW_DEFAULT,
	parameter int SCORE_W = 4,
	parameter int TOTAL_W = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           queue_not_empty,
	input  logic [SCORE_W-1:0]             score,
	output logic                           pop,
	input  gcq_pkg::cfg_t                  cfg,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [gcq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int PTR_W = $clog2(WINDOW);
	localparam logic [TOTAL_W-1:0] CONTACT_LEVEL = TOTAL_W'(WINDOW / 2);

	logic [SCORE_W-1:0]           win_q [WINDOW];
	logic [PTR_W-1:0]             ptr_q;
	logic [TOTAL_W-1:0]           total_q;
	logic [TOTAL_W-1:0]           total_d;
	gcq_pkg::phase_t              phase_q;
	gcq_pkg::phase_t              phase_d;
	logic [gcq_pkg::COUNT_W-1:0]  engage_q;
	logic [gcq_pkg::COUNT_W-1:0]  engage_d;
	logic [gcq_pkg::COUNT_W-1:0]  engage_inc;
	logic [gcq_pkg::COUNT_W-1:0]  pulse_q;
	logic [gcq_pkg::COUNT_W-1:0]  pulse_d;
	logic [gcq_pkg::COUNT_W-1:0]  pulse_inc;
	logic                         contact;
	logic                         flag_d;
	logic                         out_valid_q;
	logic                         out_flag_q;
	gcq_pkg::phase_t              out_phase_q;

	// next word may enter while the current one is being taken
	assign pop = queue_not_empty && (!out_valid_q || m_axis_tready);

	assign total_d = total_q - TOTAL_W'(win_q[ptr_q]) + TOTAL_W'(score);
	assign contact = total_d > CONTACT_LEVEL;

	assign engage_inc = (engage_q == gcq_pkg::COUNT_MAX) ? engage_q : engage_q + 1'b1;
	assign pulse_inc  = (pulse_q == gcq_pkg::COUNT_MAX) ? pulse_q : pulse_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		engage_d = engage_q;
		pulse_d  = pulse_q;
		flag_d   = 1'b0;
		unique case (phase_q)
			gcq_pkg::PH_ENGAGE: begin
				pulse_d  = '0;
				engage_d = engage_inc;
				if (!contact) begin
					phase_d = gcq_pkg::PH_IDLE;
				end else if (engage_inc > cfg.enter_hold_limit) begin
					phase_d = gcq_pkg::PH_ASSERT;
				end
			end
			gcq_pkg::PH_ASSERT: begin
				engage_d = '0;
				pulse_d  = pulse_inc;
				flag_d   = 1'b1;
				if (!contact) begin
					phase_d = gcq_pkg::PH_IDLE;
				end else if (pulse_inc > cfg.pulse_hold_limit) begin
					phase_d = gcq_pkg::PH_ENGAGE;
				end
			end
			default: begin
				// idle, and the unused code behaves as idle
				flag_d  = contact;
				phase_d = contact ? gcq_pkg::PH_ENGAGE : gcq_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= '0;
			end
			ptr_q    <= '0;
			total_q  <= '0;
			phase_q  <= gcq_pkg::PH_IDLE;
			engage_q <= '0;
			pulse_q  <= '0;
		end else if (pop) begin
			win_q[ptr_q] <= score;
			ptr_q        <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
			total_q      <= total_d;
			phase_q      <= phase_d;
			engage_q     <= engage_d;
			pulse_q      <= pulse_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_flag_q  <= flag_d;
			out_phase_q <= phase_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_phase_q, out_flag_q};

endmodule

// ===== hdl/gcq_checker.sv =====
// port-level checker for the gaze contact qualifier, bound to the top level
`include "assert_macros.svh"

module gcq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [gcq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	logic            in_acc;
	logic            out_acc;
	logic [2:0]      inflight_q;
	logic [1:0]      last_phase_q;
	logic [1:0]      cur_phase;
	logic            cur_flag;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_acc   = m_axis_tvalid && m_axis_tready;
	assign cur_phase = m_axis_tdata[2:1];
	assign cur_flag  = m_axis_tdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q   <= '0;
			last_phase_q <= gcq_pkg::PH_IDLE;
		end else begin
			if (in_acc && !out_acc) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (out_acc && !in_acc) begin
				inflight_q <= inflight_q - 1'b1;
			end
			if (out_acc) begin
				last_phase_q <= cur_phase;
			end
		end
	end

	`GCQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")
	`GCQ_ASSERT_IMPL(a_no_phantom, clk, arst_n, m_axis_tvalid, inflight_q != 3'd0, "output word without an accepted sample")
	`GCQ_ASSERT_IMPL(a_idle_step, clk, arst_n, m_axis_tvalid && (last_phase_q == gcq_pkg::PH_IDLE), cur_phase != gcq_pkg::PH_ASSERT, "idle jumped straight to asserted")
	`GCQ_ASSERT_IMPL(a_assert_flag, clk, arst_n, m_axis_tvalid && cur_flag && (cur_phase == gcq_pkg::PH_ASSERT || cur_phase == gcq_pkg::PH_IDLE), last_phase_q == gcq_pkg::PH_ASSERT, "flag set without asserted phase before")

endmodule

bind gaze_contact_qualifier_core gcq_checker u_gcq_checker (.*);

// ===== tb/tb.sv =====
// self-checking stream testbench for gaze_contact_qualifier_core with a scoring and phase predictor
`timescale 1ns / 1ps

module tb;
	import gcq_pkg::*;

	localparam int WIN = WINDOW_DEFAULT;
	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 1000;
	localparam int SHOW_LIMIT = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;

	typedef struct packed {
		logic   flag;
		phase_t phase;
	} contact_word_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] face;
		logic signed [ANGLE_W-1:0] gaze;
		logic [CONF_W-1:0]         fconf;
		logic [CONF_W-1:0]         gconf;
		logic                      typed;
		contact_word_t             word;
	} probe_t;

	localparam contact_word_t NO_WORD = '0;

	// reset registers: tol 7, threshold 100, enter 10, pulse 5
	localparam probe_t PROBES [18] = '{
		'{9'sd0, 9'sd0, 10'd0, 10'd0, 1'b1, '{1'b0, PH_IDLE}},
		'{9'h100, 9'sd255, 10'd1023, 10'd1023, 1'b1, '{1'b0, PH_IDLE}},
		'{9'sd255, 9'h100, 10'd101, 10'd101, 1'b1, '{1'b1, PH_ENGAGE}},
		'{9'sd180, -9'sd180, 10'd100, 10'd1000, 1'b1, '{1'b0, PH_ENGAGE}},
		'{9'sd6, 9'sd0, 10'd1000, 10'd1000, 1'b0, NO_WORD},
		'{9'sd7, 9'sd7, 10'd1000, 10'd1000, 1'b0, NO_WORD},
		'{9'sd0, -9'sd6, 10'd1000, 10'd1000, 1'b0, NO_WORD},
		'{-9'sd6, -9'sd12, 10'd1000, 10'd1000, 1'b0, NO_WORD},
		'{-9'sd6, -9'sd13, 10'd1000, 10'd1000, 1'b0, NO_WORD},
		'{9'sd0, 9'sd0, 10'd1000, 10'd1000, 1'b0, NO_WORD},
		'{9'sd0, 9'sd255, 10'd1000, 10'd1000, 1'b0, NO_WORD},
		'{-9'sd1, 9'sd1, 10'd101, 10'd1023, 1'b0, NO_WORD},
		'{9'sd1, -9'sd1, 10'd1023, 10'd100, 1'b0, NO_WORD},
		'{9'sd0, 9'sd0, 10'd511, 10'd512, 1'b0, NO_WORD},
		'{-9'sd255, 9'sd0, 10'd1000, 10'd1000, 1'b0, NO_WORD},
		'{9'sd100, -9'sd100, 10'd1000, 10'd1000, 1'b0, NO_WORD},
		'{-9'sd100, 9'sd100, 10'd1000, 10'd1000, 1'b0, NO_WORD},
		'{9'sd3, 9'sd9, 10'd1000, 10'd1000, 1'b0, NO_WORD}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gaze_contact_qualifier_core #(.WINDOW(WIN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	cfg_t          regs;
	int            score_hist [WIN];
	int            hist_ptr;
	int            score_sum;
	phase_t        phase_q;
	logic [COUNT_W-1:0] engage_cnt;
	logic [COUNT_W-1:0] pulse_cnt;

	contact_word_t pending_words [$];
	int            accepted_in = 0;
	int            words_out = 0;
	int            err_count = 0;
	int            settings_run = 1;
	int            phase_seen [4] = '{0, 0, 0, 0};
	int            flags_seen = 0;

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// both sides run without gaps over this stretch of words
	function automatic bit steady_now();
		return accepted_in >= 300 && accepted_in < 450;
	endfunction

	function automatic contact_word_t step_contact(input logic signed [ANGLE_W-1:0] f,
			input logic signed [ANGLE_W-1:0] g, input logic [CONF_W-1:0] fc,
			input logic [CONF_W-1:0] gc);
		int fi, gi, af, tol, pts;
		bit hit;
		contact_word_t w;
		fi = int'(f);
		gi = int'(g);
		af = magnitude(fi);
		tol = int'(regs.angle_tolerance);
		pts = 0;
		if (fc > regs.confidence_threshold && gc > regs.confidence_threshold) begin
			if ((fi < 0 && gi > 0) || (fi > 0 && gi < 0))
				pts = WIN / 3;
			else if (af < tol && magnitude(af - magnitude(gi)) < tol)
				pts = 1;
		end
		score_sum = score_sum - score_hist[hist_ptr] + pts;
		score_hist[hist_ptr] = pts;
		hist_ptr = (hist_ptr + 1 >= WIN) ? 0 : hist_ptr + 1;
		hit = score_sum > WIN / 2;
		case (phase_q)
			PH_ENGAGE: begin
				pulse_cnt = '0;
				if (engage_cnt != COUNT_MAX)
					engage_cnt++;
				if (!hit)
					phase_q = PH_IDLE;
				else if (engage_cnt > regs.enter_hold_limit)
					phase_q = PH_ASSERT;
				w.flag = 1'b0;
			end
			PH_ASSERT: begin
				engage_cnt = '0;
				if (pulse_cnt != COUNT_MAX)
					pulse_cnt++;
				if (!hit)
					phase_q = PH_IDLE;
				else if (pulse_cnt > regs.pulse_hold_limit)
					phase_q = PH_ENGAGE;
				w.flag = 1'b1;
			end
			default: begin
				// the unused code behaves as idle
				phase_q = hit ? PH_ENGAGE : PH_IDLE;
				w.flag = hit;
			end
		endcase
		w.phase = phase_q;
		return w;
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_sample(input logic signed [ANGLE_W-1:0] f,
			input logic signed [ANGLE_W-1:0] g, input logic [CONF_W-1:0] fc,
			input logic [CONF_W-1:0] gc, input bit typed, input contact_word_t typed_word);
		contact_word_t w;
		while (!steady_now() && $urandom_range(0, 99) < 27) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, gc, fc, g, f};
		do @(posedge clk); while (!s_axis_tready);
		w = step_contact(f, g, fc, gc);
		pending_words.insert(pending_words.size(), typed ? typed_word : w);
		accepted_in++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ANGLE_TOL: regs.angle_tolerance = val[TOL_W-1:0];
			REG_CONF_THR:  regs.confidence_threshold = val;
			REG_ENTER_LIM: regs.enter_hold_limit = val[LIMIT_W-1:0];
			REG_PULSE_LIM: regs.pulse_hold_limit = val[LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [CFG_DATA_W-1:0] tol, input logic [CFG_DATA_W-1:0] thr,
			input logic [CFG_DATA_W-1:0] enter, input logic [CFG_DATA_W-1:0] pulse);
		drain();
		write_reg(REG_ANGLE_TOL, tol);
		write_reg(REG_CONF_THR, thr);
		write_reg(REG_ENTER_LIM, enter);
		write_reg(REG_PULSE_LIM, pulse);
		// indexes past the list must be dropped, written last so a leak would show
		write_reg(REG_SPARE_FIRST, 10'h3FF);
		write_reg(REG_SPARE_LAST, 10'h000);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// alternating contact bursts and quiet stretches
	task automatic run_stream(input int n_items, input int burst_lo, input int burst_hi,
			input int bias);
		int left, run, k, pick, b, thr, conf_lo, tol_m, mf, mg, d, fi, gi, fci, gci, swap;
		bit hot;
		left = n_items;
		hot = 1'b1;
		while (left > 0) begin
			run = hot ? $urandom_range(burst_lo, burst_hi) : $urandom_range(3, 15);
			b = hot ? bias : 15;
			for (k = 0; k < run && left > 0; k++) begin
				thr = int'(regs.confidence_threshold);
				conf_lo = (thr >= 1023) ? 0 : thr + 1;
				tol_m = (regs.angle_tolerance == 0) ? 1 : int'(regs.angle_tolerance);
				pick = $urandom_range(0, 99);
				fci = $urandom_range(conf_lo, 1023);
				gci = $urandom_range(conf_lo, 1023);
				if (pick < b) begin
					mf = $urandom_range(1, 255);
					mg = $urandom_range(1, 256);
					if ($urandom_range(0, 1)) begin
						fi = mf;
						gi = -mg;
					end else begin
						fi = -mg;
						gi = mf;
					end
				end else if (pick < b + (100 - b) / 3) begin
					// straight look, same sign on both angles
					mf = $urandom_range(0, tol_m - 1);
					d = $urandom_range(0, tol_m - 1);
					mg = $urandom_range(0, 1) ? mf + d : mf - d;
					mg = (mg < 0) ? 0 : (mg > 255) ? 255 : mg;
					if ($urandom_range(0, 1)) begin
						fi = -mf;
						gi = -mg;
					end else begin
						fi = mf;
						gi = mg;
					end
				end else if (pick < b + 2 * (100 - b) / 3) begin
					fi = $urandom;
					gi = $urandom;
					swap = $urandom_range(0, 1);
					fci = swap ? $urandom_range(0, 1023) : $urandom_range(0, thr);
					gci = swap ? $urandom_range(0, thr) : $urandom_range(0, 1023);
				end else begin
					fi = $urandom;
					gi = $urandom;
					fci = $urandom;
					gci = $urandom;
				end
				send_sample(fi[ANGLE_W-1:0], gi[ANGLE_W-1:0], fci[CONF_W-1:0], gci[CONF_W-1:0],
					1'b0, NO_WORD);
				left--;
			end
			hot = !hot;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		contact_word_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.flag = m_axis_tdata[0];
			got.phase = phase_t'(m_axis_tdata[2:1]);
			phase_seen[m_axis_tdata[2:1]]++;
			if (got.flag)
				flags_seen++;
			if (pending_words.size() == 0) begin
				if (err_count < SHOW_LIMIT)
					$display("unexpected word %0d: flag %0d phase %0d", words_out, got.flag,
						got.phase);
				err_count++;
			end else begin
				want = pending_words.pop_front();
				if (want.flag !== got.flag || want.phase !== got.phase) begin
					if (err_count < SHOW_LIMIT)
						$display("word %0d: expected flag %0d phase %0d, got flag %0d phase %0d",
							words_out, want.flag, want.phase, got.flag, got.phase);
					err_count++;
				end
			end
			words_out++;
		end
	end

	// receiver: random stalls, plus long hold-offs that back the block up
	initial begin
		int k;
		int next_hold;
		next_hold = 150;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n && accepted_in >= next_hold) begin
				next_hold += 450;
				for (k = 0; k < HOLD_CYCLES; k++) begin
					m_axis_tready <= 1'b0;
					@(negedge clk);
				end
			end
			m_axis_tready <= steady_now() || ($urandom_range(0, 99) >= 27);
		end
	end

	// watchdog on cycles with no handshake on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d idle cycles", STALL_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int i;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		regs = CFG_RESET;
		for (i = 0; i < WIN; i++)
			score_hist[i] = 0;
		hist_ptr = 0;
		score_sum = 0;
		phase_q = PH_IDLE;
		engage_cnt = '0;
		pulse_cnt = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < $size(PROBES); i++)
			send_sample(PROBES[i].face, PROBES[i].gaze, PROBES[i].fconf, PROBES[i].gconf,
				PROBES[i].typed, PROBES[i].word);
		run_stream(80, 5, 40, 70);

		apply_setting(10'd180, 10'd0, 10'd0, 10'd0);
		run_stream(80, 5, 30, 60);
		// enter limit at max: engaging never reaches asserted, engage count runs into saturation
		apply_setting(10'd0, 10'd1000, 10'd255, 10'd254);
		run_stream(340, 30, 90, 90);
		// threshold at max: every score is zero
		apply_setting(10'd255, 10'd1023, 10'd3, 10'd2);
		run_stream(30, 5, 15, 70);
		// one long burst so the asserted count saturates
		apply_setting(10'd20, 10'd512, 10'd0, 10'd255);
		run_stream(280, 260, 280, 92);
		apply_setting(10'd3, 10'd250, 10'd6, 10'd3);
		run_stream(80, 5, 40, 70);

		drain();
		repeat (4) @(posedge clk);
		if (pending_words.size() != 0) begin
			$display("%0d expected words never arrived", pending_words.size());
			err_count += pending_words.size();
		end

		$display("%0d samples in, %0d words out over %0d register settings, %0d mismatches",
			accepted_in, words_out, settings_run, err_count);
		$display("phase idle/engaging/asserted seen %0d/%0d/%0d times, flag high %0d times",
			phase_seen[PH_IDLE], phase_seen[PH_ENGAGE], phase_seen[PH_ASSERT], flags_seen);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
